// ===== rtl/ilha_pkg.sv =====
package ilha_pkg;

   // geometry of the tag store and of the payload fields
   localparam int HEAP_WORDS      = 65536;
   localparam int IDX_W           = $clog2(HEAP_WORDS);
   localparam int ADDR_W          = 19;
   localparam int LEN_W           = 20;
   localparam int TAG_W           = 20;
   localparam int OP_W            = 2;
   localparam int STAT_W          = 2;
   localparam int SUM_W           = 21;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 20;
   localparam int MIN_BLOCK_BYTES = 24;
   localparam int WORD_BYTES      = 8;
   localparam int TAG_OVERHEAD    = 16;
   localparam int ADDR_SPACE      = 2 ** ADDR_W;
   localparam int HEAP_SPAN       = (HEAP_WORDS * WORD_BYTES < ADDR_SPACE) ?
                                    HEAP_WORDS * WORD_BYTES : ADDR_SPACE;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BYTES = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_FORMAT,
      OP_ALLOC,
      OP_FREE,
      OP_RESIZE
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK,
      STAT_OOM,
      STAT_INVALID
   } status_type;

   typedef logic [SUM_W-1:0] sum_type;

   // one write and one read of the tag store per cycle
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] widx;
      logic [TAG_W-1:0] wdata;
      logic [IDX_W-1:0] ridx;
   } mem_req_type;

   // size field of a tag
   function automatic sum_type tag_size(input logic [TAG_W-1:0] tag);
      return SUM_W'({tag[TAG_W-1:3], 3'b000});
   endfunction

   // word index of a byte address
   function automatic logic [IDX_W-1:0] tag_index(input sum_type addr);
      return IDX_W'(addr >> 3);
   endfunction

   // block at a with size s lies fully inside the heap
   function automatic logic sane(input sum_type a, input sum_type s,
                                 input sum_type lo, input sum_type hi);
      return (s >= SUM_W'(MIN_BLOCK_BYTES)) && (a >= lo) && (a <= hi) &&
             (s <= hi + SUM_W'(MIN_BLOCK_BYTES) - a);
   endfunction

   // payload size to block size
   function automatic sum_type pad_request(input logic [LEN_W-1:0] req);
      sum_type r;
      r = SUM_W'(req) + SUM_W'(WORD_BYTES - 1);
      r = {r[SUM_W-1:3], 3'b000} + SUM_W'(TAG_OVERHEAD);
      if (req <= LEN_W'(WORD_BYTES)) r = SUM_W'(MIN_BLOCK_BYTES);
      return r;
   endfunction

endpackage

// ===== rtl/ilha_ifs.sv =====
interface ilha_req_if;
   import ilha_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic [LEN_W-1:0]    request_bytes;
   logic [ADDR_W-1:0]   client_address;
   modport source (output valid, opcode, request_bytes, client_address, input ready);
   modport sink   (input valid, opcode, request_bytes, client_address, output ready);
endinterface

interface ilha_rsp_if;
   import ilha_pkg::*;
   logic                valid;
   logic                ready;
   logic [STAT_W-1:0]   status;
   logic [ADDR_W-1:0]   result_address;
   logic                copy_needed;
   logic [ADDR_W-1:0]   copy_source;
   logic [ADDR_W-1:0]   copy_dest;
   logic [LEN_W-1:0]    copy_bytes;
   modport source (output valid, status, result_address, copy_needed, copy_source,
                   copy_dest, copy_bytes, input ready);
   modport sink   (input valid, status, result_address, copy_needed, copy_source,
                   copy_dest, copy_bytes, output ready);
endinterface

interface ilha_csr_if;
   import ilha_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ilha_tag_mem.sv =====
module ilha_tag_mem (
   input  logic                          clock,
   input  ilha_pkg::mem_req_type         mem_req,
   output logic [ilha_pkg::TAG_W-1:0]    rd_data
);
   import ilha_pkg::*;

   logic [TAG_W-1:0] tag_store_ff [HEAP_WORDS];
   logic [TAG_W-1:0] rd_data_ff;

   // write port, and registered read with write forwarding
   always_ff @(posedge clock) begin
      if (mem_req.we) tag_store_ff[mem_req.widx] <= mem_req.wdata;
      if (mem_req.we && (mem_req.widx == mem_req.ridx)) begin
         rd_data_ff <= mem_req.wdata;
      end else begin
         rd_data_ff <= tag_store_ff[mem_req.ridx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ilha_ctrl.sv =====
module ilha_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   ilha_req_if.sink                      req_ch,
   ilha_rsp_if.source                    rsp_ch,
   input  logic [ilha_pkg::ADDR_W-1:0]   region_start,
   input  logic [ilha_pkg::LEN_W-1:0]    region_bytes,
   output ilha_pkg::mem_req_type         mem_req,
   input  logic [ilha_pkg::TAG_W-1:0]    rd_data
);
   import ilha_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_VB_CHK,
      S_FF_WALK,
      S_TAKE,
      S_NB_START,
      S_NB_UP,
      S_NB_LO0,
      S_NB_LO1,
      S_NB_LO2,
      S_NB_DONE,
      S_RSZ_FREE_OLD,
      S_PUT_HDR,
      S_PUT_FTR,
      S_FINISH
   } state_type;

   state_type state_ff, state_in, put_ret_ff, put_ret_in;
   state_type rel_ret_ff, rel_ret_in, take_ret_ff, take_ret_in;
   logic              formatted_ff, formatted_in;
   logic [ADDR_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   op_type            op_ff, op_in;
   sum_type           need_ff, need_in;
   logic [ADDR_W-1:0] client_ff, client_in;
   sum_type           p_ff, p_in, a_ff, a_in, s_ff, s_in;
   sum_type           up_ff, up_in, dn_ff, dn_in, d_ff, d_in;
   sum_type           old_ff, old_in, osz_ff, osz_in;
   sum_type           put_a_ff, put_a_in, put_s_ff, put_s_in;
   logic              put_alloc_ff, put_alloc_in;
   logic              rel_mode_ff, rel_mode_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in, res_src_ff, res_src_in;
   logic [ADDR_W-1:0] res_dst_ff, res_dst_in;
   logic              res_copy_ff, res_copy_in;
   logic [LEN_W-1:0]  res_bytes_ff, res_bytes_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in, rsp_src_ff, rsp_src_in;
   logic [ADDR_W-1:0] rsp_dst_ff, rsp_dst_in;
   logic              rsp_copy_ff, rsp_copy_in;
   logic [LEN_W-1:0]  rsp_bytes_ff, rsp_bytes_in;
   sum_type           rd_addr, wr_addr;
   logic              wr_en;

   // next state and datapath
   always_comb begin
      sum_type lo, hi, tsz, u, st, en, b, p_new, s_up, s_dn, s_all, need24, grow;
      lo     = SUM_W'(lo_ff);
      hi     = SUM_W'(hi_ff);
      tsz    = tag_size(rd_data);
      u      = a_ff + s_ff;
      st     = SUM_W'(region_start) + SUM_W'(WORD_BYTES - 1);
      st     = {st[SUM_W-1:3], 3'b000};
      en     = SUM_W'(region_start) + SUM_W'(region_bytes);
      en     = {en[SUM_W-1:3], 3'b000};
      if (en > SUM_W'(HEAP_SPAN)) en = SUM_W'(HEAP_SPAN);
      b      = SUM_W'(client_ff) - SUM_W'(WORD_BYTES);
      p_new  = p_ff + tsz;
      s_up   = s_ff + up_ff;
      s_dn   = s_ff + dn_ff;
      s_all  = s_dn + up_ff;
      need24 = need_ff + SUM_W'(MIN_BLOCK_BYTES);
      // lower neighbor alone when it is enough, else both neighbors
      grow   = (s_dn >= need_ff) ? s_dn : s_all;

      state_in      = state_ff;
      put_ret_in    = put_ret_ff;
      rel_ret_in    = rel_ret_ff;
      take_ret_in   = take_ret_ff;
      formatted_in  = formatted_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      op_in         = op_ff;
      need_in       = need_ff;
      client_in     = client_ff;
      p_in          = p_ff;
      a_in          = a_ff;
      s_in          = s_ff;
      up_in         = up_ff;
      dn_in         = dn_ff;
      d_in          = d_ff;
      old_in        = old_ff;
      osz_in        = osz_ff;
      put_a_in      = put_a_ff;
      put_s_in      = put_s_ff;
      put_alloc_in  = put_alloc_ff;
      rel_mode_in   = rel_mode_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_copy_in   = res_copy_ff;
      res_src_in    = res_src_ff;
      res_dst_in    = res_dst_ff;
      res_bytes_in  = res_bytes_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_copy_in   = rsp_copy_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_dst_in    = rsp_dst_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rd_addr       = a_ff;
      wr_addr       = put_a_ff;
      wr_en         = 1'b0;

      // output word leaves
      if (rsp_ch.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in         = op_type'(req_ch.opcode);
               need_in       = pad_request(req_ch.request_bytes);
               client_in     = req_ch.client_address;
               res_status_in = STAT_OK;
               res_addr_in   = '0;
               res_copy_in   = 1'b0;
               res_src_in    = '0;
               res_dst_in    = '0;
               res_bytes_in  = '0;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (op_ff)
               OP_FORMAT: begin
                  if (en < st || en - st < SUM_W'(MIN_BLOCK_BYTES)) begin
                     formatted_in  = 1'b0;
                     res_status_in = STAT_OOM;
                     state_in      = S_FINISH;
                  end else begin
                     formatted_in = 1'b1;
                     lo_in        = ADDR_W'(st);
                     hi_in        = ADDR_W'(en - SUM_W'(MIN_BLOCK_BYTES));
                     put_a_in     = st;
                     put_s_in     = en - st;
                     put_alloc_in = 1'b0;
                     put_ret_in   = S_FINISH;
                     state_in     = S_PUT_HDR;
                  end
               end
               OP_ALLOC: begin
                  rd_addr = lo;
                  p_in    = lo;
                  if (!formatted_ff) begin
                     res_status_in = STAT_OOM;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = S_FF_WALK;
                  end
               end
               default: begin
                  // free and resize start with a check of the client block
                  rd_addr = b;
                  a_in    = b;
                  if (!formatted_ff || client_ff < ADDR_W'(WORD_BYTES) ||
                      client_ff[2:0] != 3'b000 || b < lo || b > hi) begin
                     res_status_in = STAT_INVALID;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = S_VB_CHK;
                  end
               end
            endcase
         end
         S_VB_CHK: begin
            if (!rd_data[0] || !sane(a_ff, tsz, lo, hi)) begin
               res_status_in = STAT_INVALID;
               state_in      = S_FINISH;
            end else begin
               s_in   = tsz;
               old_in = a_ff;
               osz_in = tsz;
               if (op_ff == OP_FREE) begin
                  rel_mode_in = 1'b1;
                  rel_ret_in  = S_FINISH;
                  state_in    = S_NB_START;
               end else if (tsz >= need_ff) begin
                  take_ret_in = S_FINISH;
                  res_addr_in = client_ff;
                  state_in    = S_TAKE;
               end else begin
                  rel_mode_in = 1'b0;
                  state_in    = S_NB_START;
               end
            end
         end
         S_FF_WALK: begin
            // one block tag per cycle, next address straight from the tag
            rd_addr = p_new;
            if (p_ff > hi || !sane(p_ff, tsz, lo, hi)) begin
               res_status_in = STAT_OOM;
               state_in      = S_FINISH;
            end else if (!rd_data[0] && tsz >= need_ff) begin
               a_in        = p_ff;
               s_in        = tsz;
               res_addr_in = ADDR_W'(p_ff + SUM_W'(WORD_BYTES));
               take_ret_in = S_FINISH;
               if (op_ff == OP_RESIZE) begin
                  res_copy_in  = 1'b1;
                  res_src_in   = ADDR_W'(old_ff);
                  res_dst_in   = ADDR_W'(p_ff);
                  res_bytes_in = LEN_W'(osz_ff);
                  take_ret_in  = S_RSZ_FREE_OLD;
               end
               state_in = S_TAKE;
            end else begin
               p_in = p_new;
            end
         end
         S_TAKE: begin
            put_a_in     = a_ff;
            put_alloc_in = 1'b1;
            if (s_ff >= need24) begin
               // split, the remainder is released
               put_s_in    = need_ff;
               a_in        = a_ff + need_ff;
               s_in        = s_ff - need_ff;
               rel_mode_in = 1'b1;
               rel_ret_in  = take_ret_ff;
               put_ret_in  = S_NB_START;
            end else begin
               put_s_in   = s_ff;
               put_ret_in = take_ret_ff;
            end
            state_in = S_PUT_HDR;
         end
         S_NB_START: begin
            rd_addr = u;
            if (u > hi) begin
               up_in    = '0;
               state_in = S_NB_LO0;
            end else begin
               state_in = S_NB_UP;
            end
         end
         S_NB_UP: begin
            up_in    = (rd_data[0] || !sane(u, tsz, lo, hi)) ? '0 : tsz;
            state_in = S_NB_LO0;
         end
         S_NB_LO0: begin
            rd_addr = a_ff - SUM_W'(WORD_BYTES);
            if (a_ff < lo + SUM_W'(MIN_BLOCK_BYTES)) begin
               dn_in    = '0;
               state_in = S_NB_DONE;
            end else begin
               state_in = S_NB_LO1;
            end
         end
         S_NB_LO1: begin
            // footer of the lower neighbor gives its header address
            rd_addr = a_ff - tsz;
            if (tsz < SUM_W'(MIN_BLOCK_BYTES) || tsz > a_ff - lo) begin
               dn_in    = '0;
               state_in = S_NB_DONE;
            end else begin
               d_in     = a_ff - tsz;
               dn_in    = tsz;
               state_in = S_NB_LO2;
            end
         end
         S_NB_LO2: begin
            if (rd_data[0] || tsz != dn_ff || !sane(d_ff, tsz, lo, hi)) dn_in = '0;
            state_in = S_NB_DONE;
         end
         S_NB_DONE: begin
            if (rel_mode_ff) begin
               put_a_in     = (dn_ff != '0) ? d_ff : a_ff;
               put_s_in     = s_all;
               put_alloc_in = 1'b0;
               put_ret_in   = rel_ret_ff;
               state_in     = S_PUT_HDR;
            end else begin
               // resize growth: upper, lower, both, else relocate
               put_alloc_in = 1'b1;
               if (s_up >= need_ff) begin
                  s_in        = s_up;
                  take_ret_in = S_FINISH;
                  res_addr_in = client_ff;
                  state_in    = S_TAKE;
               end else if (grow >= need24) begin
                  put_a_in     = grow - need_ff + d_ff;
                  put_s_in     = need_ff;
                  put_ret_in   = S_NB_START;
                  a_in         = d_ff;
                  s_in         = grow - need_ff;
                  rel_mode_in  = 1'b1;
                  rel_ret_in   = S_FINISH;
                  res_copy_in  = 1'b1;
                  res_src_in   = ADDR_W'(a_ff);
                  res_dst_in   = ADDR_W'(grow - need_ff + d_ff);
                  res_bytes_in = LEN_W'(s_ff);
                  res_addr_in  = ADDR_W'(grow - need_ff + d_ff + SUM_W'(WORD_BYTES));
                  state_in     = S_PUT_HDR;
               end else if (grow >= need_ff) begin
                  put_a_in     = d_ff;
                  put_s_in     = grow;
                  put_ret_in   = S_FINISH;
                  res_copy_in  = 1'b1;
                  res_src_in   = ADDR_W'(a_ff);
                  res_dst_in   = ADDR_W'(d_ff);
                  res_bytes_in = LEN_W'(s_ff);
                  res_addr_in  = ADDR_W'(d_ff + SUM_W'(WORD_BYTES));
                  state_in     = S_PUT_HDR;
               end else begin
                  rd_addr  = lo;
                  p_in     = lo;
                  state_in = S_FF_WALK;
               end
            end
         end
         S_RSZ_FREE_OLD: begin
            a_in        = old_ff;
            s_in        = osz_ff;
            rel_mode_in = 1'b1;
            rel_ret_in  = S_FINISH;
            state_in    = S_NB_START;
         end
         S_PUT_HDR: begin
            wr_en    = 1'b1;
            wr_addr  = put_a_ff;
            state_in = S_PUT_FTR;
         end
         S_PUT_FTR: begin
            wr_en    = 1'b1;
            wr_addr  = put_a_ff + put_s_ff - SUM_W'(WORD_BYTES);
            state_in = put_ret_ff;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_copy_in   = res_copy_ff;
               rsp_src_in    = res_src_ff;
               rsp_dst_in    = res_dst_ff;
               rsp_bytes_in  = res_bytes_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign mem_req.we    = wr_en;
   assign mem_req.widx  = tag_index(wr_addr);
   assign mem_req.wdata = TAG_W'(put_s_ff) | TAG_W'(put_alloc_ff);
   assign mem_req.ridx  = tag_index(rd_addr);

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.result_address = rsp_addr_ff;
   assign rsp_ch.copy_needed    = rsp_copy_ff;
   assign rsp_ch.copy_source    = rsp_src_ff;
   assign rsp_ch.copy_dest      = rsp_dst_ff;
   assign rsp_ch.copy_bytes     = rsp_bytes_ff;

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         formatted_ff <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         formatted_ff <= formatted_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      put_ret_ff    <= put_ret_in;
      rel_ret_ff    <= rel_ret_in;
      take_ret_ff   <= take_ret_in;
      op_ff         <= op_in;
      need_ff       <= need_in;
      client_ff     <= client_in;
      p_ff          <= p_in;
      a_ff          <= a_in;
      s_ff          <= s_in;
      up_ff         <= up_in;
      dn_ff         <= dn_in;
      d_ff          <= d_in;
      old_ff        <= old_in;
      osz_ff        <= osz_in;
      put_a_ff      <= put_a_in;
      put_s_ff      <= put_s_in;
      put_alloc_ff  <= put_alloc_in;
      rel_mode_ff   <= rel_mode_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_copy_ff   <= res_copy_in;
      res_src_ff    <= res_src_in;
      res_dst_ff    <= res_dst_in;
      res_bytes_ff  <= res_bytes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_copy_ff   <= rsp_copy_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_dst_ff    <= rsp_dst_in;
      rsp_bytes_ff  <= rsp_bytes_in;
   end

`ifndef NO_ASSERTIONS
   a_heap_bounds: assert property (@(posedge clock) disable iff (reset)
      formatted_ff |-> lo_ff <= hi_ff)
      else $error("formatted heap with lowest block above highest block");

   a_copy_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_copy_ff) |-> rsp_status_ff == STAT_OK)
      else $error("copy request on a failed operation");

   a_walk_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FF_WALK |-> p_ff[2:0] == 3'b000)
      else $error("first-fit walk left word alignment");

   a_put_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PUT_HDR |->
         (put_a_ff[2:0] == 3'b000 && put_s_ff >= SUM_W'(MIN_BLOCK_BYTES)))
      else $error("block tag write with bad address or size");
`endif

endmodule

// ===== rtl/implicit_list_heap_allocator.sv =====
// channel | role   | words
// req_ch  | sink   | opcode, request_bytes, client_address
// rsp_ch  | source | status, result_address, copy fields
// csr_ch  | sink   | region_start (index 0), region_bytes (index 1)
//
// every tag access goes through the tag memory, one write and one read a cycle
// format writes a single free block; free takes longer by how many neighbors are read
// allocate and relocating resize take longer for every block passed in the walk
// reset clears control state only; tag memory stays undefined until formatted
// a finished word waits in the output register while the next request is taken
module implicit_list_heap_allocator (
   input  logic       clock,
   input  logic       reset,
   ilha_req_if.sink   req_ch,
   ilha_rsp_if.source rsp_ch,
   ilha_csr_if.sink   csr_ch
);
   import ilha_pkg::*;

   logic [ADDR_W-1:0] region_start_ff;
   logic [LEN_W-1:0]  region_bytes_ff;
   mem_req_type       mem_req;
   logic [TAG_W-1:0]  rd_data;

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= '0;
         region_bytes_ff <= LEN_W'(ADDR_SPACE);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_REGION_START: region_start_ff <= csr_ch.data[ADDR_W-1:0];
            CSR_REGION_BYTES: region_bytes_ff <= csr_ch.data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   ilha_tag_mem u_tag_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ilha_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .region_start (region_start_ff),
      .region_bytes (region_bytes_ff),
      .mem_req      (mem_req),
      .rd_data      (rd_data)
   );

endmodule

// ===== sim/tb.sv =====
module tb;
   import ilha_pkg::*;

   // one expected answer word
   typedef struct {
      status_type        status;
      logic [ADDR_W-1:0] addr;
      logic              copy;
      logic [ADDR_W-1:0] src;
      logic [ADDR_W-1:0] dst;
      logic [LEN_W-1:0]  bytes;
   } answer_type;

   // tracks the heap layout and the answers still owed by the block
   class heap_tracker;
      int unsigned tags[HEAP_WORDS];
      int unsigned stamp[HEAP_WORDS];
      int unsigned epoch;
      int unsigned lowest;
      int unsigned highest;
      bit          formatted;
      int unsigned reg_start;
      int unsigned reg_bytes;
      int unsigned live[$];
      answer_type  owed[$];
      int          errors;

      function new();
         epoch     = 1;
         lowest    = 0;
         highest   = 0;
         formatted = 0;
         reg_start = 0;
         reg_bytes = ADDR_SPACE;
         errors    = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, int unsigned val);
         if (idx == CSR_REGION_START) reg_start = val & 32'h7FFFF;
         else reg_bytes = val & 32'hFFFFF;
      endfunction

      function int unsigned rd(int unsigned a);
         return tags[(a >> 3) % HEAP_WORDS];
      endfunction

      function void wr(int unsigned a, int unsigned v);
         tags[(a >> 3) % HEAP_WORDS]  = v & 32'hFFFFF;
         stamp[(a >> 3) % HEAP_WORDS] = epoch;
      endfunction

      function bit fits(int unsigned a, int unsigned s);
         if (s < MIN_BLOCK_BYTES || a < lowest || a > highest) return 0;
         return s <= highest + MIN_BLOCK_BYTES - a;
      endfunction

      function void put_block(int unsigned a, int unsigned s, int unsigned al);
         wr(a, s | al);
         wr(a + s - WORD_BYTES, s | al);
      endfunction

      function int unsigned room_above(int unsigned a, int unsigned s);
         int unsigned u, t, sz;
         u = a + s;
         if (u > highest) return 0;
         t  = rd(u);
         sz = t & 32'hFFFF8;
         if ((t & 1) || !fits(u, sz)) return 0;
         return sz;
      endfunction

      function int unsigned room_below(int unsigned a, output int unsigned where);
         int unsigned f, d, t, sz;
         where = 0;
         if (a < lowest + MIN_BLOCK_BYTES) return 0;
         f = rd(a - WORD_BYTES) & 32'hFFFF8;
         if (f < MIN_BLOCK_BYTES || f > a - lowest) return 0;
         d  = a - f;
         t  = rd(d);
         sz = t & 32'hFFFF8;
         if ((t & 1) || sz != f || !fits(d, sz)) return 0;
         where = d;
         return sz;
      endfunction

      // free a block and merge it with free neighbors
      function void release_block(int unsigned a, int unsigned s);
         int unsigned d, fb;
         s += room_above(a, s);
         fb = room_below(a, d);
         if (fb != 0) begin
            a = d;
            s += fb;
         end
         put_block(a, s, 0);
      endfunction

      function int unsigned pad_size(int unsigned req);
         if (req <= WORD_BYTES) return MIN_BLOCK_BYTES;
         return ((req + 7) & ~32'd7) + TAG_OVERHEAD;
      endfunction

      function bit first_fit(int unsigned need, output int unsigned at,
                             output int unsigned size);
         int unsigned p, t, s;
         p    = lowest;
         at   = 0;
         size = 0;
         while (p <= highest) begin
            t = rd(p);
            s = t & 32'hFFFF8;
            if (!fits(p, s)) return 0;
            if (!(t & 1) && s >= need) begin
               at   = p;
               size = s;
               return 1;
            end
            p += s;
         end
         return 0;
      endfunction

      function void take_block(int unsigned p, int unsigned s, int unsigned need);
         if (s >= need + MIN_BLOCK_BYTES) begin
            put_block(p, need, 1);
            release_block(p + need, s - need);
         end else begin
            put_block(p, s, 1);
         end
      endfunction

      function bit owned_block(int unsigned client, output int unsigned blk,
                               output int unsigned size);
         int unsigned b, t;
         blk  = 0;
         size = 0;
         if (!formatted || client < WORD_BYTES || (client & 7)) return 0;
         b = client - WORD_BYTES;
         if (b < lowest || b > highest) return 0;
         t = rd(b);
         if (!(t & 1) || !fits(b, t & 32'hFFFF8)) return 0;
         blk  = b;
         size = t & 32'hFFFF8;
         return 1;
      endfunction

      // header of this payload would be read but is no block of the current chain
      function bit unknown_header(int unsigned client);
         int unsigned b, p, s;
         if (!formatted || client < WORD_BYTES || (client & 7)) return 0;
         b = client - WORD_BYTES;
         if (b < lowest || b > highest) return 0;
         if (stamp[(b >> 3) % HEAP_WORDS] != epoch) return 1;
         p = lowest;
         while (p <= highest) begin
            if (p == b) return 0;
            s = rd(p) & 32'hFFFF8;
            if (!fits(p, s) || p > b) return 1;
            p += s;
         end
         return 1;
      endfunction

      function void drop_live(int unsigned a);
         foreach (live[i]) if (live[i] == a) begin
            live.delete(i);
            return;
         end
      endfunction

      function void set_copy(ref answer_type r, input int unsigned s,
                             input int unsigned d, input int unsigned n);
         r.copy  = 1;
         r.src   = ADDR_W'(s);
         r.dst   = ADDR_W'(d);
         r.bytes = LEN_W'(n);
      endfunction

      function answer_type resize_answer(int unsigned client, int unsigned req);
         answer_type  r;
         int unsigned old, osz, need, up, dn, d, p, s;
         r = '{STAT_OK, 0, 0, 0, 0, 0};
         if (!owned_block(client, old, osz)) begin
            r.status = STAT_INVALID;
            return r;
         end
         need = pad_size(req);
         if (osz >= need) begin
            take_block(old, osz, need);
            r.addr = ADDR_W'(client);
            return r;
         end
         up = room_above(old, osz);
         dn = room_below(old, d);
         if (osz + up >= need) begin
            take_block(old, osz + up, need);
            r.addr = ADDR_W'(client);
         end else if (osz + dn >= need + MIN_BLOCK_BYTES) begin
            p = old + osz - need;
            set_copy(r, old, p, osz);
            put_block(p, need, 1);
            release_block(d, osz + dn - need);
            r.addr = ADDR_W'(p + WORD_BYTES);
         end else if (osz + dn >= need) begin
            set_copy(r, old, d, osz);
            put_block(d, osz + dn, 1);
            r.addr = ADDR_W'(d + WORD_BYTES);
         end else if (osz + dn + up >= need + MIN_BLOCK_BYTES) begin
            p = old + osz + up - need;
            set_copy(r, old, p, osz);
            put_block(p, need, 1);
            release_block(d, osz + up + dn - need);
            r.addr = ADDR_W'(p + WORD_BYTES);
         end else if (osz + dn + up >= need) begin
            set_copy(r, old, d, osz);
            put_block(d, osz + dn + up, 1);
            r.addr = ADDR_W'(d + WORD_BYTES);
         end else if (!first_fit(need, p, s)) begin
            r.status = STAT_OOM;
         end else begin
            set_copy(r, old, p, osz);
            take_block(p, s, need);
            release_block(old, osz);
            r.addr = ADDR_W'(p + WORD_BYTES);
         end
         return r;
      endfunction

      // predict the answer to an accepted request word
      function void note(op_type op, int unsigned req, int unsigned client);
         answer_type  r;
         int unsigned start, stop, p, s;
         r = '{STAT_OK, 0, 0, 0, 0, 0};
         case (op)
            OP_FORMAT: begin
               live.delete();
               start = (reg_start + 7) & ~32'd7;
               stop  = (reg_start + reg_bytes) & ~32'd7;
               if (stop > HEAP_SPAN) stop = HEAP_SPAN;
               if (stop < start || stop - start < MIN_BLOCK_BYTES) begin
                  formatted = 0;
                  r.status  = STAT_OOM;
               end else begin
                  lowest    = start;
                  highest   = stop - MIN_BLOCK_BYTES;
                  formatted = 1;
                  epoch++;
                  put_block(start, stop - start, 0);
               end
            end
            OP_ALLOC: begin
               if (!formatted || !first_fit(pad_size(req), p, s)) begin
                  r.status = STAT_OOM;
               end else begin
                  take_block(p, s, pad_size(req));
                  r.addr = ADDR_W'(p + WORD_BYTES);
                  live.push_back(p + WORD_BYTES);
               end
            end
            OP_FREE: begin
               if (owned_block(client, p, s)) begin
                  release_block(p, s);
                  drop_live(client);
               end else begin
                  r.status = STAT_INVALID;
               end
            end
            default: begin
               r = resize_answer(client, req);
               if (r.status == STAT_OK) begin
                  drop_live(client);
                  live.push_back(r.addr);
               end
            end
         endcase
         owed.push_back(r);
      endfunction

      // compare a returned answer word with the oldest prediction
      function void check(answer_type got);
         answer_type want;
         if (owed.size() == 0) begin
            $error("answer word with nothing expected: status %0d addr %0h",
                   got.status, got.addr);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.addr !== want.addr) begin
            $error("result_address: expected %0h, actual %0h", want.addr, got.addr);
            errors++;
         end
         if (got.copy !== want.copy) begin
            $error("copy_needed: expected %0d, actual %0d", want.copy, got.copy);
            errors++;
         end
         if (got.src !== want.src) begin
            $error("copy_source: expected %0h, actual %0h", want.src, got.src);
            errors++;
         end
         if (got.dst !== want.dst) begin
            $error("copy_dest: expected %0h, actual %0h", want.dst, got.dst);
            errors++;
         end
         if (got.bytes !== want.bytes) begin
            $error("copy_bytes: expected %0h, actual %0h", want.bytes, got.bytes);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_gap_pct;
   int   recv_stall_pct;
   int   quiet_cycles;

   heap_tracker heap = new();

   ilha_req_if req_if();
   ilha_rsp_if rsp_if();
   ilha_csr_if csr_if();

   implicit_list_heap_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source),
      .csr_ch (csr_if.sink)
   );

   // clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // receiver with random stalls
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // answer monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         heap.check('{status_type'(rsp_if.status), rsp_if.result_address,
                      rsp_if.copy_needed, rsp_if.copy_source, rsp_if.copy_dest,
                      rsp_if.copy_bytes});
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 200000) begin
         $display("implicit_list_heap_allocator test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(op_type op, int unsigned req, int unsigned client);
      while ($urandom_range(99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.opcode         <= op;
      req_if.request_bytes  <= LEN_W'(req);
      req_if.client_address <= ADDR_W'(client);
      do @(posedge clock); while (!req_if.ready);
      heap.note(op, req, client);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (heap.owed.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      heap.set_reg(idx, val);
   endtask

   // payload address: mostly a live block, otherwise anything that reads no stale word
   function automatic int unsigned pick_client();
      int unsigned c;
      if (heap.live.size() != 0 && $urandom_range(99) < 75)
         c = heap.live[$urandom_range(heap.live.size() - 1)];
      else if ($urandom_range(1))
         c = heap.lowest + 8 * $urandom_range(64);
      else
         c = $urandom_range(ADDR_SPACE - 1);
      if (heap.unknown_header(c)) c = c | 1;
      return c;
   endfunction

   function automatic int unsigned pick_size();
      int unsigned roll, span;
      roll = $urandom_range(99);
      span = heap.highest + MIN_BLOCK_BYTES - heap.lowest;
      if (roll < 60) return $urandom_range(64);
      if (roll < 85) return $urandom_range(span / 4);
      if (roll < 97) return $urandom_range(ADDR_SPACE);
      return ($urandom_range(1)) ? ADDR_SPACE : 9;
   endfunction

   task automatic random_request();
      int roll;
      roll = $urandom_range(99);
      if (roll < 2) send_request(OP_FORMAT, $urandom_range(ADDR_SPACE), pick_client());
      else if (roll < 45) send_request(OP_ALLOC, pick_size(), pick_client());
      else if (roll < 72) send_request(OP_FREE, pick_size(), pick_client());
      else send_request(OP_RESIZE, pick_size(), pick_client());
   endtask

   int unsigned p_start[8] = '{0, 1000, 5, 4096, 100, 524287, 0, 65536};
   int unsigned p_bytes[8] = '{524288, 200, 3000, 2500, 20, 524288, 0, 8000};
   int          p_items[8] = '{270, 150, 170, 170, 20, 20, 20, 200};

   initial begin
      int unsigned a;
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.opcode         = OP_FORMAT;
      req_if.request_bytes  = '0;
      req_if.client_address = '0;
      csr_if.valid          = 1'b0;
      csr_if.index          = CSR_REGION_START;
      csr_if.data           = '0;
      send_gap_pct          = 0;
      recv_stall_pct        = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unformatted heap
      send_request(OP_ALLOC, 16, 0);
      send_request(OP_FREE, 0, 8);
      send_request(OP_RESIZE, 32, 16);
      wait_drained();

      // region too small to format
      write_reg(CSR_REGION_START, 100);
      write_reg(CSR_REGION_BYTES, 20);
      send_request(OP_FORMAT, 0, 0);
      send_request(OP_ALLOC, 0, 0);
      wait_drained();

      // directed walk through the operations on a small heap
      write_reg(CSR_REGION_START, 3);
      write_reg(CSR_REGION_BYTES, 400);
      send_request(OP_FORMAT, 0, 0);
      send_request(OP_ALLOC, 0, 0);
      send_request(OP_ALLOC, 8, 0);
      send_request(OP_ALLOC, 9, 0);
      send_request(OP_ALLOC, ADDR_SPACE, 0);
      send_request(OP_ALLOC, 40, 0);
      a = heap.live[1];
      send_request(OP_FREE, 0, a);
      send_request(OP_FREE, 0, a);
      send_request(OP_FREE, 0, a + 1);
      send_request(OP_FREE, 0, 0);
      send_request(OP_RESIZE, 0, heap.live[0]);
      send_request(OP_RESIZE, 120, heap.live[0]);
      send_request(OP_RESIZE, 100, heap.live[heap.live.size() - 1]);
      send_request(OP_RESIZE, ADDR_SPACE, heap.live[0]);
      send_request(OP_RESIZE, 8, 7);
      wait_drained();

      // random phases over several region settings and idling modes
      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         send_gap_pct   = (ph % 4 == 1) ? 55 : (ph % 4 == 3) ? 8 : 0;
         recv_stall_pct = (ph % 4 == 2) ? 55 : (ph % 4 == 3) ? 8 : 0;
         write_reg(CSR_REGION_START, p_start[ph]);
         write_reg(CSR_REGION_BYTES, p_bytes[ph]);
         send_request(OP_FORMAT, 0, 0);
         for (int i = 0; i < p_items[ph]; i++) random_request();
      end
      wait_drained();
      repeat (50) @(posedge clock);

      if (heap.errors == 0 && heap.owed.size() == 0)
         $display("implicit_list_heap_allocator test passed");
      else
         $display("implicit_list_heap_allocator test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ilha_pkg.sv
rtl/ilha_ifs.sv
rtl/ilha_tag_mem.sv
rtl/ilha_ctrl.sv
rtl/implicit_list_heap_allocator.sv
sim/tb.sv
